@@ rtl/core/midi_command_trigger_matcher_macros.svh @@
// ----------------------------------------------------------------------------
// MIDI command trigger matcher: assertion macros
// Concurrent assertion shorthands, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_COMMAND_TRIGGER_MATCHER_MACROS_SVH
`define MIDI_COMMAND_TRIGGER_MATCHER_MACROS_SVH

// Same-cycle implication.
`define MCTM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MCTM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/mctm_pkg.sv @@
// ----------------------------------------------------------------------------
// mctm_pkg
// Types, codes and field widths of the MIDI command trigger matcher.
// ----------------------------------------------------------------------------
package mctm_pkg;

  // field widths
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned NumW     = 7;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned EChanW   = 5;
  localparam int unsigned ChainW   = 6;

  // program map depth: one entry per program number
  localparam int unsigned Programs = 128;

  // request modes
  localparam logic [ModeW-1:0] MODE_MSG  = 2'd0;
  localparam logic [ModeW-1:0] MODE_TRIG = 2'd1;
  localparam logic [ModeW-1:0] MODE_MAP  = 2'd2;

  // message kinds
  localparam logic MSG_NOTE_ON  = 1'b0;
  localparam logic MSG_PROG_CHG = 1'b1;

  // result kinds
  localparam logic RES_CHAIN = 1'b0;
  localparam logic RES_TRIG  = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic              msg_kind;
    logic [ChanW-1:0]  midi_channel;
    logic [NumW-1:0]   note_or_program;
    logic [NumW-1:0]   velocity;
    logic [SlotW-1:0]  slot_index;
    logic              entry_active;
    logic              entry_kind;
    logic [EChanW-1:0] entry_channel;
    logic [NumW-1:0]   entry_number;
    logic [NumW-1:0]   entry_threshold;
    logic [ChainW-1:0] chain_number;
  } req_t;

  typedef struct packed {
    logic              result_kind;
    logic [ChainW-1:0] chain_out;
    logic [NumW-1:0]   program_out;
    logic [SlotW-1:0]  trigger_slot;
    logic              last;
  } rsp_t;

  // trigger slot payload; the active flag lives in flops
  typedef struct packed {
    logic              kind;
    logic [EChanW-1:0] channel;
    logic [NumW-1:0]   number;
    logic [NumW-1:0]   threshold;
  } trig_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSCAN,
    ST_MWR,
    ST_PRD,
    ST_PCHK,
    ST_TRD,
    ST_TCMP,
    ST_FIN
  } state_e;

endpackage

@@ rtl/core/mctm_stream_if.sv @@
// ----------------------------------------------------------------------------
// mctm_stream_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface mctm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/mctm_ram.sv @@
// ----------------------------------------------------------------------------
// mctm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mctm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/midi_command_trigger_matcher.sv @@
// ----------------------------------------------------------------------------
// midi_command_trigger_matcher
// Matches note-on / program-change requests against a trigger table and a
// program-to-chain map; also takes table and map writes.
// ----------------------------------------------------------------------------
//
//  port   dir   modport  payload  notes
//  req_i  in    sink     req_t    message, trigger write or map write
//  rsp_o  out   source   rsp_t    chain switch / fired slot, last flag
//
//  Trigger write: written straight from the accepted request. Map write: one pass over all 128
//  map entries through the map RAM read port, then the write.
//  Note-on: each trigger slot is read (ST_TRD), then compared (ST_TCMP), before
//  the next slot is read; program change first reads and checks the map.
//  Output stalls add cycles only when a finished match has to wait on a full
//  output register. req_i.ready is high only between requests.
//  Reset clears all slot active flags and map valid flags at once.
//
`include "midi_command_trigger_matcher_macros.svh"

module midi_command_trigger_matcher
  import mctm_pkg::*;
#(
  parameter int unsigned TRIGGER_SLOTS = 32,
  parameter int unsigned CHAIN_COUNT   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mctm_stream_if.sink   req_i,
  mctm_stream_if.source rsp_o
);

  localparam int unsigned SIdxW  = (TRIGGER_SLOTS > 1) ? $clog2(TRIGGER_SLOTS) : 1;
  localparam int unsigned PIdxW  = $clog2(Programs);
  localparam logic [SIdxW-1:0] SlotLast = SIdxW'(TRIGGER_SLOTS - 1);
  localparam logic [PIdxW-1:0] ProgLast = PIdxW'(Programs - 1);

  // --------------------------------------------------------------------------
  // request capture
  // --------------------------------------------------------------------------
  req_t req;
  logic req_acc;

  assign req     = req_i.payload;
  assign req_acc = req_i.valid && req_i.ready;

  state_e state_q, state_d;

  logic              kind_q;
  logic [ChanW-1:0]  chan_q;
  logic [NumW-1:0]   num_q;
  logic [NumW-1:0]   vel_q;
  logic [ChainW-1:0] chain_q;

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q  <= req.msg_kind;
      chan_q  <= req.midi_channel;
      num_q   <= req.note_or_program;
      vel_q   <= req.velocity;
      chain_q <= req.chain_number;
    end
  end

  logic trig_wr_ok;
  logic map_wr_ok;

  assign trig_wr_ok = (32'(req.slot_index) < 32'(TRIGGER_SLOTS));
  assign map_wr_ok  = (32'(req.chain_number) < 32'(CHAIN_COUNT));

  // --------------------------------------------------------------------------
  // trigger table: payload in RAM, active flags in flops
  // --------------------------------------------------------------------------
  logic                   trig_we;
  trig_entry_t            trig_wdata;
  logic [$bits(trig_entry_t)-1:0] trig_rdata;
  logic [SIdxW-1:0]       slot_cnt_q;
  logic [TRIGGER_SLOTS-1:0] active_q;

  assign trig_we    = req_acc && (req.mode == MODE_TRIG) && trig_wr_ok;
  assign trig_wdata = '{kind:      req.entry_kind,
                        channel:   req.entry_channel,
                        number:    req.entry_number,
                        threshold: req.entry_threshold};

  mctm_ram #(
    .Width ($bits(trig_entry_t)),
    .Depth (TRIGGER_SLOTS)
  ) u_trig_ram (
    .clk_i   (clk_i),
    .we_i    (trig_we),
    .waddr_i (SIdxW'(req.slot_index)),
    .wdata_i (trig_wdata),
    .raddr_i (slot_cnt_q),
    .rdata_o (trig_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (trig_we) begin
      active_q[SIdxW'(req.slot_index)] <= req.entry_active;
    end
  end

  // slot compare: the shared match unit, one slot per pass
  trig_entry_t ent;
  logic        chan_ok;
  logic        vel_ok;
  logic        trig_hit;

  assign ent     = trig_entry_t'(trig_rdata);
  assign chan_ok = (ent.channel == '0) || (ent.channel == ({1'b0, chan_q} + 5'd1));
  // threshold only gates note-on, and zero disables it
  assign vel_ok  = (kind_q == MSG_PROG_CHG) || (ent.threshold == '0) ||
                   (vel_q >= ent.threshold);
  assign trig_hit = active_q[slot_cnt_q] && (ent.kind == kind_q) && chan_ok &&
                    (ent.number == num_q) && vel_ok;

  // --------------------------------------------------------------------------
  // program map: chain in RAM, valid flags in flops
  // --------------------------------------------------------------------------
  logic [PIdxW-1:0]  map_cnt_q;
  logic [PIdxW-1:0]  map_raddr;
  logic [ChainW-1:0] map_rdata;
  logic [Programs-1:0] map_valid_q;
  logic [Programs-1:0] map_valid_d;
  logic              cmp_act_q;
  logic [PIdxW-1:0]  cmp_idx_q;
  logic              cmp_hit;

  assign map_raddr = (state_q == ST_MSCAN) ? map_cnt_q : num_q;

  mctm_ram #(
    .Width (ChainW),
    .Depth (Programs)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_MWR),
    .waddr_i (num_q),
    .wdata_i (chain_q),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // scan pipeline: read issued one cycle, compared the next
  assign cmp_hit = cmp_act_q && map_valid_q[cmp_idx_q] && (map_rdata == chain_q);

  // drop old pointers to the chain, then the new entry wins
  always_comb begin
    map_valid_d = map_valid_q;
    if (cmp_hit) begin
      map_valid_d[cmp_idx_q] = 1'b0;
    end
    if (state_q == ST_MWR) begin
      map_valid_d[num_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_act_q   <= 1'b0;
      map_valid_q <= '0;
    end else begin
      cmp_act_q   <= (state_q == ST_MSCAN);
      map_valid_q <= map_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= map_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_cnt_q <= '0;
    end else if (req_acc) begin
      map_cnt_q <= '0;
    end else if (state_q == ST_MSCAN) begin
      map_cnt_q <= map_cnt_q + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // pending result and output register
  // --------------------------------------------------------------------------
  // A match is held as pending until the next match or the end of the scan
  // shows whether it is the last one.
  logic pend_q;
  rsp_t pend_rsp_q;
  logic out_valid_q;
  rsp_t out_q;
  logic out_free;

  assign out_free = !out_valid_q || rsp_o.ready;

  // --------------------------------------------------------------------------
  // sequencer: next state
  // --------------------------------------------------------------------------
  logic tcmp_stall;

  assign tcmp_stall = trig_hit && pend_q && !out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          case (req.mode)
            MODE_MSG: state_d = (req.msg_kind == MSG_PROG_CHG) ? ST_PRD : ST_TRD;
            MODE_MAP: state_d = map_wr_ok ? ST_MSCAN : ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_MSCAN: begin
        if (map_cnt_q == ProgLast) begin
          state_d = ST_MWR;
        end
      end
      ST_MWR:  state_d = ST_IDLE;
      ST_PRD:  state_d = ST_PCHK;
      ST_PCHK: state_d = ST_TRD;
      ST_TRD:  state_d = ST_TCMP;
      ST_TCMP: begin
        if (!tcmp_stall) begin
          state_d = (slot_cnt_q == SlotLast) ? ST_FIN : ST_TRD;
        end
      end
      ST_FIN: begin
        if (!pend_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer: datapath controls
  // --------------------------------------------------------------------------
  logic emit;
  logic emit_last;
  logic pend_chain;
  logic pend_trig;
  logic pend_clr;
  logic slot_inc;

  always_comb begin
    emit       = 1'b0;
    emit_last  = 1'b0;
    pend_chain = 1'b0;
    pend_trig  = 1'b0;
    pend_clr   = 1'b0;
    slot_inc   = 1'b0;
    case (state_q)
      ST_PCHK: begin
        pend_chain = map_valid_q[num_q];
      end
      ST_TCMP: begin
        if (!tcmp_stall) begin
          slot_inc  = (slot_cnt_q != SlotLast);
          pend_trig = trig_hit;
          emit      = trig_hit && pend_q;
        end
      end
      ST_FIN: begin
        if (pend_q && out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          pend_clr  = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_cnt_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (req_acc) begin
        slot_cnt_q <= '0;
      end else if (slot_inc) begin
        slot_cnt_q <= slot_cnt_q + 1'b1;
      end
      if (pend_chain || pend_trig) begin
        pend_q <= 1'b1;
      end else if (pend_clr) begin
        pend_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_chain) begin
      pend_rsp_q <= '{result_kind:  RES_CHAIN,
                      chain_out:    map_rdata,
                      program_out:  num_q,
                      trigger_slot: '0,
                      last:         1'b0};
    end else if (pend_trig) begin
      pend_rsp_q <= '{result_kind:  RES_TRIG,
                      chain_out:    '0,
                      program_out:  '0,
                      trigger_slot: SlotW'(slot_cnt_q),
                      last:         1'b0};
    end
    if (emit) begin
      out_q <= '{result_kind:  pend_rsp_q.result_kind,
                 chain_out:    pend_rsp_q.chain_out,
                 program_out:  pend_rsp_q.program_out,
                 trigger_slot: pend_rsp_q.trigger_slot,
                 last:         emit_last};
    end
  end

  assign req_i.ready   = (state_q == ST_IDLE);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `MCTM_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_q,
    "pending result left over between requests")
  `MCTM_ASSERT_NXT(a_map_wr_sets, state_q == ST_MWR, map_valid_q[num_q],
    "mapped program not valid after map write")
  `MCTM_ASSERT_IMP(a_slot_steady, state_q == ST_TCMP, $stable(slot_cnt_q),
    "slot index moved between read and compare")

endmodule
